// File: rtl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and constants for the selectable string hash block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int CHAR_W = 8;
  localparam int HASH_W = 32;
  localparam int OUT_W  = 31;
  localparam int ALG_W  = 3;

  typedef enum logic [ALG_W-1:0] {
    ALG_SDBM = 3'd0,
    ALG_RS   = 3'd1,
    ALG_JS   = 3'd2,
    ALG_PJW  = 3'd3,
    ALG_ELF  = 3'd4,
    ALG_BKDR = 3'd5,
    ALG_DJB  = 3'd6,
    ALG_AP   = 3'd7
  } alg_t;

  typedef logic [HASH_W-1:0] word_t;

  localparam word_t RS_STEP   = 32'd378551;
  localparam word_t RS_START  = 32'd63689;
  localparam word_t JS_START  = 32'd1315423911;
  localparam word_t PJW_TOP   = 32'hF000_0000;
  localparam word_t BKDR_SEED = 32'd131;
  localparam word_t DJB_START = 32'd5381;

  function automatic word_t start_value(input alg_t alg);
    word_t v;
    case (alg)
      ALG_JS:  v = JS_START;
      ALG_DJB: v = DJB_START;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ssh_in_if.sv
// ----------------------------------------------------------------------------
// ssh_in_if
// Character request channel: valid/ready handshake with one signed byte.
// ----------------------------------------------------------------------------
interface ssh_in_if import ssh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CHAR_W-1:0] character;
  logic                     last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// File: rtl/ssh_out_if.sv
// ----------------------------------------------------------------------------
// ssh_out_if
// Hash result channel: valid/ready handshake with the 31-bit hash.
// ----------------------------------------------------------------------------
interface ssh_out_if import ssh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// File: rtl/selectable_string_hash.sv
// ----------------------------------------------------------------------------
// selectable_string_hash
// Character-at-a-time string hash with eight selectable classic hashes.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one character request per handshake, last marks the string end
//   digest : one hash_value request per string, the low 31 bits of the hash
//   cfg_we/cfg_wdata : selects the hash and restarts the running state;
//     write only while no string is in progress
// Result path: a last character is held in the input register, then
//   loaded into the result register when digest is free; digest takes
//   it from there.
// Throughput: one character per cycle unless a last character waits; set
//   by the single fold stage with its 32x32 multiply for the RS hash.
// Reset: clears the pipeline, selects SDBM and restarts the running hash.
//   text.ready is low while rst is high.
// Stall: a waiting hash holds in the result register; characters that do
//   not end a string keep flowing, a last character waits in the input
//   register until the result register frees.
// ----------------------------------------------------------------------------
module selectable_string_hash
  import ssh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ALG_W-1:0] cfg_wdata,
  ssh_in_if.sink           text,
  ssh_out_if.source        digest
);

  alg_t                     algorithm;
  word_t                    running_hash;
  word_t                    rs_multiplier;
  logic                     odd_position;

  logic                     s1_valid;
  logic signed [CHAR_W-1:0] s1_char;
  logic                     s1_last;

  logic                     out_valid;
  logic [OUT_W-1:0]         out_hash;

  logic                     out_free;
  logic                     s1_advance;
  word_t                    c32;
  word_t                    hash_next;
  word_t                    pjw_sum;

  assign out_free   = !out_valid || digest.ready;
  assign s1_advance = s1_valid && (!s1_last || out_free);
  assign text.ready = !rst && (!s1_valid || s1_advance);

  assign digest.valid      = out_valid;
  assign digest.hash_value = out_hash;

  assign c32     = {{(HASH_W-CHAR_W){s1_char[CHAR_W-1]}}, s1_char};
  assign pjw_sum = (running_hash << 4) + c32;

  always_comb begin
    case (algorithm)
      ALG_SDBM: begin
        hash_next = c32 + (running_hash << 6) + (running_hash << 16) - running_hash;
      end
      ALG_RS: begin
        hash_next = running_hash * rs_multiplier + c32;
      end
      ALG_JS: begin
        hash_next = running_hash ^ ((running_hash << 5) + c32 + (running_hash >> 2));
      end
      ALG_PJW, ALG_ELF: begin
        if ((pjw_sum & PJW_TOP) != '0) begin
          hash_next = (pjw_sum ^ ((pjw_sum & PJW_TOP) >> 24)) & ~PJW_TOP;
        end else begin
          hash_next = pjw_sum;
        end
      end
      ALG_BKDR: begin
        hash_next = (running_hash << 7) + (running_hash << 1) + running_hash + c32;
      end
      ALG_DJB: begin
        hash_next = running_hash + (running_hash << 5) + c32;
      end
      ALG_AP: begin
        if (!odd_position) begin
          hash_next = running_hash ^ ((running_hash << 7) ^ c32 ^ (running_hash >> 3));
        end else begin
          hash_next = running_hash ^ ~((running_hash << 11) ^ c32 ^ (running_hash >> 5));
        end
      end
      default: begin
        hash_next = running_hash;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (text.valid && text.ready) begin
      s1_char <= text.character;
      s1_last <= text.last;
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm     <= ALG_SDBM;
      running_hash  <= start_value(ALG_SDBM);
      rs_multiplier <= RS_START;
      odd_position  <= 1'b0;
    end else if (cfg_we) begin
      algorithm     <= alg_t'(cfg_wdata);
      running_hash  <= start_value(alg_t'(cfg_wdata));
      rs_multiplier <= RS_START;
      odd_position  <= 1'b0;
    end else if (s1_advance) begin
      if (s1_last) begin
        running_hash  <= start_value(algorithm);
        rs_multiplier <= RS_START;
        odd_position  <= 1'b0;
      end else begin
        running_hash  <= hash_next;
        rs_multiplier <= rs_multiplier * RS_STEP;
        odd_position  <= !odd_position;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_last) begin
      out_hash <= hash_next[OUT_W-1:0];
    end
  end

endmodule

// File: rtl/ssh_checker.sv
// ----------------------------------------------------------------------------
// ssh_checker
// Port-level checks for selectable_string_hash, bound to the top level.
// ----------------------------------------------------------------------------
module ssh_checker
  import ssh_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             text_valid,
  input logic             text_ready,
  input logic             text_last,
  input logic             digest_valid,
  input logic             digest_ready,
  input logic [OUT_W-1:0] digest_hash_value
);

  // a stalled request holds
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid)
    else $error("digest valid dropped while stalled");

  a_digest_stable: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> $stable(digest_hash_value))
    else $error("digest payload changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !digest_valid)
    else $error("digest valid after reset");

  // a new hash only follows an accepted last character, through the input and result registers
  a_rise_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> $past(text_valid && text_ready && text_last, 2))
    else $error("hash without a last character");

endmodule

bind selectable_string_hash ssh_checker u_ssh_checker (
  .clk               (clk),
  .rst               (rst),
  .text_valid        (text.valid),
  .text_ready        (text.ready),
  .text_last         (text.last),
  .digest_valid      (digest.valid),
  .digest_ready      (digest.ready),
  .digest_hash_value (digest.hash_value)
);
